/* hw/rtl/cpb_pkg.sv */
// shared constants and codes for the clipped palette pixel blitter
package cpb_pkg;

  localparam int unsigned COLOR_W = 16;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned PIDX_W  = 8;
  localparam int unsigned XY_W    = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned MODE_W  = 3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  localparam logic [MODE_W-1:0] MODE_RGB555     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DIRECT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PALETTE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PAL_BRIGHT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NONE       = 3'd4;

  localparam logic [CIDX_W-1:0] REG_DEST_X        = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DEST_Y        = 3'd1;
  localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_PIXEL_MODE    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;
  localparam logic [CIDX_W-1:0] REG_LINE_STRIDE   = 3'd7;

  localparam logic [DIM_W-1:0] RST_IMAGE_DIM     = 13'd1;
  localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [DIM_W-1:0] RST_LINE_STRIDE   = 13'd640;

endpackage

/* hw/rtl/cpb_ram.sv */
// generic single-write, single-read ram with registered read data
module cpb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/cpb_pos.sv */
// column and row counters with screen position and clip test
module cpb_pos #(
  parameter int unsigned MAX_DIM = 4096,
  parameter int unsigned POS_W   = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       adv,
  input  logic [cpb_pkg::XY_W-1:0]   dest_x,
  input  logic [cpb_pkg::XY_W-1:0]   dest_y,
  input  logic [cpb_pkg::DIM_W-1:0]  image_width,
  input  logic [cpb_pkg::DIM_W-1:0]  image_height,
  input  logic [cpb_pkg::DIM_W-1:0]  screen_width,
  input  logic [cpb_pkg::DIM_W-1:0]  screen_height,
  output logic [POS_W-1:0]           sx,
  output logic [POS_W-1:0]           sy,
  output logic                       on_screen
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned LIM_W = (CNT_W + 1 > cpb_pkg::DIM_W) ? CNT_W + 1 : cpb_pkg::DIM_W;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [LIM_W-1:0] eff_w, eff_h;
  logic [LIM_W-1:0] w_ext, h_ext;
  logic [LIM_W-1:0] col_inc, row_inc;

  assign w_ext = LIM_W'(image_width);
  assign h_ext = LIM_W'(image_height);

  always_comb begin
    if (image_width == '0) begin
      eff_w = LIM_W'(1);
    end else if (w_ext > LIM_W'(MAX_DIM)) begin
      eff_w = LIM_W'(MAX_DIM);
    end else begin
      eff_w = w_ext;
    end
    if (image_height == '0) begin
      eff_h = LIM_W'(1);
    end else if (h_ext > LIM_W'(MAX_DIM)) begin
      eff_h = LIM_W'(MAX_DIM);
    end else begin
      eff_h = h_ext;
    end
  end

  assign col_inc = LIM_W'(col_r) + LIM_W'(1);
  assign row_inc = LIM_W'(row_r) + LIM_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (clr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (adv) begin
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        if (row_inc >= eff_h) begin
          row_nxt = '0;
        end else begin
          row_nxt = CNT_W'(row_inc);
        end
      end else begin
        col_nxt = CNT_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign sx = POS_W'(dest_x) + POS_W'(col_r);
  assign sy = POS_W'(dest_y) + POS_W'(row_r);
  assign on_screen = (sx < POS_W'(screen_width)) && (sy < POS_W'(screen_height));

endmodule

/* hw/rtl/clipped_palette_pixel_blitter.sv */
// top level of the clipped palette pixel blitter
//
// Input channel (in_valid/in_ready) carries either a palette load (in_func 0:
// in_palette_index, in_palette_value) or a source pixel (in_func 1: in_pixel_data)
// in row order. Each drawn pixel leaves on the result channel (out_valid/out_ready)
// as one framebuffer write: out_write_address, out_write_color. Clipped,
// transparent and mode-none pixels advance the position but give no transfer.
// Configuration is a write port (cfg_we, cfg_index, cfg_wdata); any write
// restarts the picture at column 0, row 0. Write it only while the block is idle.
// A drawn pixel passes stage 1, stage 2 and the output register to out_valid.
// Throughput: one item per cycle while the receiver takes the results; the palette
// ram takes one write or one read a cycle, and the 3-stage pipe (palette read,
// stride multiply, address add) takes a new item whenever its first stage moves on.
// Reset clears the counters, the pipe and the registers to their defaults;
// palette contents are undefined until loaded.
// When the receiver stalls the pipe fills and in_ready drops after 3 drawn pixels.
module clipped_palette_pixel_blitter #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned MAX_DIM       = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cpb_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [cpb_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [cpb_pkg::PIDX_W-1:0]          in_palette_index,
  input  logic [cpb_pkg::COLOR_W-1:0]         in_palette_value,
  input  logic [cpb_pkg::COLOR_W-1:0]         in_pixel_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cpb_pkg::ADDR_W-1:0]          out_write_address,
  output logic [cpb_pkg::COLOR_W-1:0]         out_write_color
);

  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned BASE_W = (CNT_W > cpb_pkg::XY_W) ? CNT_W : cpb_pkg::XY_W;
  localparam int unsigned POS_W  = BASE_W + 1;
  localparam int unsigned PROD_W = POS_W + cpb_pkg::DIM_W;
  localparam int unsigned PA_W   = $clog2(PALETTE_DEPTH);

  // configuration registers
  logic [cpb_pkg::XY_W-1:0]   dest_x_r, dest_y_r;
  logic [cpb_pkg::DIM_W-1:0]  image_width_r, image_height_r;
  logic [cpb_pkg::MODE_W-1:0] pixel_mode_r;
  logic [cpb_pkg::DIM_W-1:0]  screen_width_r, screen_height_r, line_stride_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r        <= '0;
      dest_y_r        <= '0;
      image_width_r   <= cpb_pkg::RST_IMAGE_DIM;
      image_height_r  <= cpb_pkg::RST_IMAGE_DIM;
      pixel_mode_r    <= cpb_pkg::MODE_NONE;
      screen_width_r  <= cpb_pkg::RST_SCREEN_WIDTH;
      screen_height_r <= cpb_pkg::RST_SCREEN_HEIGHT;
      line_stride_r   <= cpb_pkg::RST_LINE_STRIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        cpb_pkg::REG_DEST_X:        dest_x_r        <= cfg_wdata[cpb_pkg::XY_W-1:0];
        cpb_pkg::REG_DEST_Y:        dest_y_r        <= cfg_wdata[cpb_pkg::XY_W-1:0];
        cpb_pkg::REG_IMAGE_WIDTH:   image_width_r   <= cfg_wdata;
        cpb_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= cfg_wdata;
        cpb_pkg::REG_PIXEL_MODE:    pixel_mode_r    <= cfg_wdata[cpb_pkg::MODE_W-1:0];
        cpb_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        cpb_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        cpb_pkg::REG_LINE_STRIDE:   line_stride_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_rdy, s2_rdy, s1_rdy;
  logic in_xfer, pix_xfer, load_xfer;

  assign out_rdy   = !out_v_r || out_ready;
  assign s2_rdy    = !s2_v_r || out_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_ready  = s1_rdy;
  assign in_xfer   = in_valid && in_ready;
  assign pix_xfer  = in_xfer && (in_func == cpb_pkg::FUNC_PIXEL);
  assign load_xfer = in_xfer && (in_func == cpb_pkg::FUNC_LOAD);

  // position and clipping
  logic [POS_W-1:0] pos_sx, pos_sy;
  logic             pos_on_screen;

  cpb_pos #(
    .MAX_DIM (MAX_DIM),
    .POS_W   (POS_W)
  ) u_pos (
    .clk           (clk),
    .rst_n         (rst_n),
    .clr           (cfg_we),
    .adv           (pix_xfer),
    .dest_x        (dest_x_r),
    .dest_y        (dest_y_r),
    .image_width   (image_width_r),
    .image_height  (image_height_r),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .sx            (pos_sx),
    .sy            (pos_sy),
    .on_screen     (pos_on_screen)
  );

  // palette memory
  logic                          load_in_range, pix_in_range;
  logic [PA_W-1:0]               ram_waddr, ram_raddr;
  logic [cpb_pkg::COLOR_W-1:0]   ram_rdata;
  logic [cpb_pkg::PIDX_W-1:0]    pix_idx;

  assign pix_idx       = in_pixel_data[cpb_pkg::PIDX_W-1:0];
  assign load_in_range = ({1'b0, in_palette_index} < (cpb_pkg::PIDX_W+1)'(PALETTE_DEPTH));
  assign pix_in_range  = ({1'b0, pix_idx} < (cpb_pkg::PIDX_W+1)'(PALETTE_DEPTH));
  assign ram_waddr     = PA_W'(in_palette_index);
  assign ram_raddr     = PA_W'(pix_idx);

  cpb_ram #(
    .WIDTH (cpb_pkg::COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (load_xfer && load_in_range),
    .waddr (ram_waddr),
    .wdata (in_palette_value),
    .re    (pix_xfer && pix_in_range),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stage 1: filter out items that draw nothing
  logic draws;

  always_comb begin
    case (pixel_mode_r)
      cpb_pkg::MODE_RGB555:     draws = 1'b1;
      cpb_pkg::MODE_DIRECT:     draws = 1'b1;
      cpb_pkg::MODE_PALETTE:    draws = (pix_idx != '0);
      cpb_pkg::MODE_PAL_BRIGHT: draws = (pix_idx != '0);
      default:                  draws = 1'b0;
    endcase
  end

  logic [POS_W-1:0]            s1_sx_r, s1_sy_r;
  logic [cpb_pkg::MODE_W-1:0]  s1_mode_r;
  logic [cpb_pkg::COLOR_W-1:0] s1_d_r;
  logic                        s1_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= pix_xfer && pos_on_screen && draws;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_sx_r   <= pos_sx;
      s1_sy_r   <= pos_sy;
      s1_mode_r <= pixel_mode_r;
      s1_d_r    <= in_pixel_data;
      s1_oor_r  <= !pix_in_range;
    end
  end

  // stage 2: color conversion and stride multiply
  logic [cpb_pkg::COLOR_W-1:0] pal_color, conv_color;

  assign pal_color = s1_oor_r ? '0 : ram_rdata;

  always_comb begin
    case (s1_mode_r)
      cpb_pkg::MODE_RGB555:     conv_color = {s1_d_r[14:5], 1'b0, s1_d_r[4:0]};
      cpb_pkg::MODE_DIRECT:     conv_color = s1_d_r;
      cpb_pkg::MODE_PALETTE:    conv_color = pal_color;
      cpb_pkg::MODE_PAL_BRIGHT: conv_color = pal_color + {pal_color[15:5], 5'b0};
      default:                  conv_color = '0;
    endcase
  end

  logic [PROD_W-1:0]           s2_prod_r;
  logic [POS_W-1:0]            s2_sx_r;
  logic [cpb_pkg::COLOR_W-1:0] s2_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_prod_r  <= PROD_W'(s1_sy_r) * PROD_W'(line_stride_r);
      s2_sx_r    <= s1_sx_r;
      s2_color_r <= conv_color;
    end
  end

  // output register: address add
  logic [cpb_pkg::ADDR_W-1:0]  out_addr_r;
  logic [cpb_pkg::COLOR_W-1:0] out_color_r;
  logic [PROD_W-1:0]           addr_sum;

  assign addr_sum = s2_prod_r + PROD_W'(s2_sx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_addr_r  <= addr_sum[cpb_pkg::ADDR_W-1:0];
      out_color_r <= s2_color_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_write_address = out_addr_r;
  assign out_write_color   = out_color_r;

  // checks
  a_clip_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_xfer && !pos_on_screen) |=> !s1_v_r)
    else $error("clipped pixel entered the pipe");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_rdy) |=> (s1_v_r && $stable(s1_sy_r) && $stable(s1_sx_r)))
    else $error("stage 1 lost its item under stall");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (pos_sx == POS_W'(dest_x_r)) && (pos_sy == POS_W'(dest_y_r)))
    else $error("config write did not restart the picture");

  a_s1_mode: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_mode_r == cpb_pkg::MODE_RGB555 || s1_mode_r == cpb_pkg::MODE_DIRECT ||
                s1_mode_r == cpb_pkg::MODE_PALETTE || s1_mode_r == cpb_pkg::MODE_PAL_BRIGHT))
    else $error("non-drawing mode reached the pipe");

endmodule

/* test/clipped_palette_pixel_blitter_tb.sv */
// self-checking testbench for the clipped palette pixel blitter
module clipped_palette_pixel_blitter_tb;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam logic [cpb_pkg::MODE_W-1:0] MODE_LAST = 3'd7;

  typedef struct packed {
    logic [cpb_pkg::ADDR_W-1:0]  addr;
    logic [cpb_pkg::COLOR_W-1:0] color;
  } fb_write_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [cpb_pkg::CIDX_W-1:0]   cfg_index = '0;
  logic [cpb_pkg::CFG_W-1:0]    cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_func = cpb_pkg::FUNC_LOAD;
  logic [cpb_pkg::PIDX_W-1:0]   in_palette_index = '0;
  logic [cpb_pkg::COLOR_W-1:0]  in_palette_value = '0;
  logic [cpb_pkg::COLOR_W-1:0]  in_pixel_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [cpb_pkg::ADDR_W-1:0]   out_write_address;
  logic [cpb_pkg::COLOR_W-1:0]  out_write_color;

  // blitter state as the predictor sees it
  logic [cpb_pkg::XY_W-1:0]     x_org, y_org;
  logic [cpb_pkg::DIM_W-1:0]    img_w, img_h, scr_w, scr_h, stride;
  logic [cpb_pkg::MODE_W-1:0]   blit_mode;
  logic [cpb_pkg::COLOR_W-1:0]  clut [256];
  int unsigned                  col_pos, row_pos;
  fb_write_t                    pending_writes [$];

  // palette entries the stimulus has loaded so far
  bit                           loaded [256];
  int unsigned                  loaded_list [$];

  int unsigned                  errors = 0;
  int unsigned                  cycles = 0;
  int unsigned                  burst_left = 0;
  int unsigned                  stall_left = 0;
  int unsigned                  stall_style = 0;

  clipped_palette_pixel_blitter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_palette_index  (in_palette_index),
    .in_palette_value  (in_palette_value),
    .in_pixel_data     (in_pixel_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_color   (out_write_color)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("clipped_palette_pixel_blitter verification failed");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 150);
    end
    stall_left--;
    case (stall_style)
      0: out_ready = 1'b1;
      1: out_ready = 1'($urandom_range(0, 1));
      2: out_ready = ($urandom_range(0, 7) == 0);
      default: out_ready = (cycles % 5) != 0;
    endcase
  end

  function automatic int unsigned clamp_size(logic [cpb_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (32'(v) > 4096) return 4096;
    return 32'(v);
  endfunction

  task automatic predict_pixel(input logic [cpb_pkg::COLOR_W-1:0] d);
    int unsigned col, row, sx, sy, a;
    logic [cpb_pkg::COLOR_W-1:0] color, t;
    bit draw;
    col = col_pos;
    row = row_pos;
    if (col + 1 >= clamp_size(img_w)) begin
      col_pos = 0;
      row_pos = (row + 1 >= clamp_size(img_h)) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    sx = 32'(x_org) + col;
    sy = 32'(y_org) + row;
    if (sx >= 32'(scr_w) || sy >= 32'(scr_h)) return;
    draw = 1'b1;
    color = d;
    case (blit_mode)
      cpb_pkg::MODE_RGB555: color = ((d & ~16'h1F) << 1) | (d & 16'h1F);
      cpb_pkg::MODE_DIRECT: color = d;
      cpb_pkg::MODE_PALETTE, cpb_pkg::MODE_PAL_BRIGHT: begin
        if (d[7:0] == '0) begin
          draw = 1'b0;
        end else begin
          t = clut[d[7:0]];
          color = (blit_mode == cpb_pkg::MODE_PAL_BRIGHT) ? t + (t & ~16'h1F) : t;
        end
      end
      default: draw = 1'b0;
    endcase
    if (draw) begin
      a = sy * 32'(stride) + sx;
      pending_writes.push_back('{addr: a[cpb_pkg::ADDR_W-1:0], color: color});
    end
  endtask

  // result checking and prediction, sampled at the rising edge
  always @(posedge clk) begin
    fb_write_t want;
    if (!rst_n) begin
      x_org = '0; y_org = '0;
      img_w = cpb_pkg::RST_IMAGE_DIM; img_h = cpb_pkg::RST_IMAGE_DIM;
      blit_mode = cpb_pkg::MODE_NONE;
      scr_w = cpb_pkg::RST_SCREEN_WIDTH; scr_h = cpb_pkg::RST_SCREEN_HEIGHT;
      stride = cpb_pkg::RST_LINE_STRIDE;
      col_pos = 0; row_pos = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          errors++;
          $error("unexpected write transfer: address %h color %h",
                 out_write_address, out_write_color);
        end else begin
          want = pending_writes.pop_front();
          if (out_write_address !== want.addr) begin
            errors++;
            $error("write_address expected %h actual %h", want.addr, out_write_address);
          end
          if (out_write_color !== want.color) begin
            errors++;
            $error("write_color expected %h actual %h", want.color, out_write_color);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          cpb_pkg::REG_DEST_X:        x_org = cfg_wdata[cpb_pkg::XY_W-1:0];
          cpb_pkg::REG_DEST_Y:        y_org = cfg_wdata[cpb_pkg::XY_W-1:0];
          cpb_pkg::REG_IMAGE_WIDTH:   img_w = cfg_wdata;
          cpb_pkg::REG_IMAGE_HEIGHT:  img_h = cfg_wdata;
          cpb_pkg::REG_PIXEL_MODE:    blit_mode = cfg_wdata[cpb_pkg::MODE_W-1:0];
          cpb_pkg::REG_SCREEN_WIDTH:  scr_w = cfg_wdata;
          cpb_pkg::REG_SCREEN_HEIGHT: scr_h = cfg_wdata;
          cpb_pkg::REG_LINE_STRIDE:   stride = cfg_wdata;
          default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
      end
      if (in_valid && in_ready) begin
        if (in_func == cpb_pkg::FUNC_LOAD) clut[in_palette_index] = in_palette_value;
        else predict_pixel(in_pixel_data);
      end
    end
  end

  task automatic send_item(input logic func, input logic [cpb_pkg::PIDX_W-1:0] pidx,
                           input logic [cpb_pkg::COLOR_W-1:0] pval,
                           input logic [cpb_pkg::COLOR_W-1:0] pdata);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid         = 1'b1;
    in_func          = func;
    in_palette_index = pidx;
    in_palette_value = pval;
    in_pixel_data    = pdata;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pixel(input logic [cpb_pkg::COLOR_W-1:0] d);
    send_item(cpb_pkg::FUNC_PIXEL, 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)), d);
  endtask

  task automatic load_color(input logic [cpb_pkg::PIDX_W-1:0] idx,
                            input logic [cpb_pkg::COLOR_W-1:0] value);
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(32'(idx));
    end
    send_item(cpb_pkg::FUNC_LOAD, idx, value, 16'($urandom_range(0, 65535)));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [cpb_pkg::CIDX_W-1:0] idx,
                           input logic [cpb_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic configure_blit(input logic [cpb_pkg::CFG_W-1:0] dx, dy, w, h, mode,
                                sw, sh, str);
    wait_idle();
    write_reg(cpb_pkg::REG_DEST_X, dx);
    write_reg(cpb_pkg::REG_DEST_Y, dy);
    write_reg(cpb_pkg::REG_IMAGE_WIDTH, w);
    write_reg(cpb_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(cpb_pkg::REG_PIXEL_MODE, mode);
    write_reg(cpb_pkg::REG_SCREEN_WIDTH, sw);
    write_reg(cpb_pkg::REG_SCREEN_HEIGHT, sh);
    write_reg(cpb_pkg::REG_LINE_STRIDE, str);
  endtask

  function automatic logic [cpb_pkg::PIDX_W-1:0] pick_index();
    if (loaded_list.size() == 0 || $urandom_range(0, 9) == 0) return '0;
    return 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  // mode none after reset draws nothing but still moves the counters
  task automatic test_reset_state();
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
  endtask

  task automatic test_color_modes();
    load_color(8'h01, 16'hFFFF);
    load_color(8'h80, 16'h8421);
    load_color(8'hFF, 16'h0000);
    configure_blit(0, 0, 4, 4, cpb_pkg::CFG_W'(cpb_pkg::MODE_RGB555), 640, 480, 640);
    send_pixel(16'hFFFF);
    send_pixel(16'h001F);
    send_pixel(16'hFFE0);
    send_pixel(16'h0000);
    wait_idle();
    write_reg(cpb_pkg::REG_PIXEL_MODE, cpb_pkg::CFG_W'(cpb_pkg::MODE_DIRECT));
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    wait_idle();
    write_reg(cpb_pkg::REG_PIXEL_MODE, cpb_pkg::CFG_W'(cpb_pkg::MODE_PALETTE));
    send_pixel(16'hFF00);
    send_pixel(16'h5580);
    send_pixel(16'h00FF);
    send_pixel(16'hAA01);
    wait_idle();
    write_reg(cpb_pkg::REG_PIXEL_MODE, cpb_pkg::CFG_W'(cpb_pkg::MODE_PAL_BRIGHT));
    send_pixel(16'h0001);
    send_pixel(16'h0080);
    send_pixel(16'h0100);
    for (int m = int'(cpb_pkg::MODE_NONE) + 1; m <= int'(MODE_LAST); m++) begin
      wait_idle();
      write_reg(cpb_pkg::REG_PIXEL_MODE, cpb_pkg::CFG_W'(m));
      send_pixel(16'h1234);
    end
  endtask

  task automatic test_clipping();
    // picture hangs over the right and bottom edges, stride of zero
    configure_blit(2, 1, 3, 2, cpb_pkg::CFG_W'(cpb_pkg::MODE_DIRECT), 4, 2, 0);
    for (int i = 0; i < 6; i++) send_pixel(16'(16'h0101 * i));
    // whole picture off the screen
    configure_blit(13'h1FFF, 0, 2, 1, cpb_pkg::CFG_W'(cpb_pkg::MODE_DIRECT), 4095, 10, 100);
    send_pixel(16'hBEEF);
    // far corner with the largest stride, address wraps
    configure_blit(4095, 4095, 8191, 8191, cpb_pkg::CFG_W'(cpb_pkg::MODE_RGB555),
                   8191, 8191, 8191);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    // zero sizes act as one pixel, so every pixel hits the same spot
    configure_blit(0, 0, 0, 0, cpb_pkg::CFG_W'(cpb_pkg::MODE_DIRECT), 1, 1, 0);
    send_pixel(16'h0001);
    send_pixel(16'h0002);
    send_pixel(16'h0003);
  endtask

  function automatic logic [cpb_pkg::CFG_W-1:0] pick_dim(int unsigned typical);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4096;
      2: return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(1, typical));
    endcase
  endfunction

  task automatic test_random_pictures();
    logic [cpb_pkg::CFG_W-1:0] dx, dy, sw, sh, mode;
    int unsigned phase_items;
    for (int p = 0; p < 12; p++) begin
      dx   = 13'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(0, 20));
      dy   = 13'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(0, 12));
      sw   = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(1, 24));
      sh   = 13'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(1, 12));
      mode = 13'(($urandom_range(0, 4) == 0)
                 ? $urandom_range(32'(cpb_pkg::MODE_NONE), 32'(MODE_LAST))
                 : $urandom_range(32'(cpb_pkg::MODE_RGB555), 32'(cpb_pkg::MODE_PAL_BRIGHT)));
      configure_blit(dx, dy, pick_dim(12), pick_dim(6), mode, sw, sh,
                     13'($urandom_range(0, 8191)));
      phase_items = $urandom_range(60, 190);
      for (int i = 0; i < phase_items; i++) begin
        if ($urandom_range(0, 6) == 0)
          load_color(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        else if (mode[cpb_pkg::MODE_W-1:0] == cpb_pkg::MODE_PALETTE ||
                 mode[cpb_pkg::MODE_W-1:0] == cpb_pkg::MODE_PAL_BRIGHT)
          send_pixel({8'($urandom_range(0, 255)), pick_index()});
        else
          send_pixel(16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_color_modes();
    test_clipping();
    test_random_pictures();
    wait_idle();
    if (errors == 0) begin
      $display("clipped_palette_pixel_blitter verification clean");
    end else begin
      $display("clipped_palette_pixel_blitter verification failed");
    end
    $finish;
  end

endmodule
